@@ rtl/frustum_sphere_cull_top_macros.svh @@
// ----------------------------------------------------------------------------
// frustum sphere cull assertion macros
// shared concurrent assertion forms, removed with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_SPHERE_CULL_TOP_MACROS_SVH
`define FRUSTUM_SPHERE_CULL_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FSC_ASSERT_IMPL(name, clk, rst, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("fsc implication check failed");
// next-cycle implication
`define FSC_ASSERT_NEXT(name, clk, rst, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("fsc next-cycle check failed");
`else
`define FSC_ASSERT_IMPL(name, clk, rst, a, b)
`define FSC_ASSERT_NEXT(name, clk, rst, a, b)
`endif
`endif

@@ rtl/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg
// types and constants shared by the frustum sphere culler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fsc_pkg;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_EXTRACT = 2'd1;
  localparam logic [1:0] ACT_TEST    = 2'd2;

  // bit p set: plane p is w + o, clear: w - o
  localparam logic [5:0] PLANE_ADD = 6'b100110;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T_MUL, S_T_ADD, S_T_ADDD, S_T_CMP, S_T_OUT,
    S_C_MUL, S_C_ADD, S_C_WR,
    S_P_RDW, S_P_WR,
    S_N_MUL, S_N_ADD, S_N_SQI, S_N_SQS, S_N_CHK,
    S_N_DVI, S_N_DVS, S_N_DVW
  } fsc_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CAPTURE,
    OP_MUL_CLIP, OP_MUL_TEST, OP_MUL_SQ,
    OP_ACC, OP_ACC_D, OP_CMP, OP_CLIP_WR,
    OP_RD_W, OP_PLANE_WR, OP_SQ_ADD,
    OP_SQRT_INIT, OP_SQRT_STEP,
    OP_DIV_INIT, OP_DIV_STEP, OP_DIV_WR
  } fsc_op_t;

  typedef struct packed {
    fsc_op_t    op;
    logic [3:0] idx;
    logic [1:0] k;
    logic [2:0] p;
    logic [1:0] j;
  } fsc_cmd_t;

  typedef struct packed {
    logic len_zero;
  } fsc_status_t;

endpackage

@@ rtl/fsc_datapath.sv @@
// ----------------------------------------------------------------------------
// fsc_datapath
// matrix and plane storage, shared multiplier, sqrt and divide units
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fsc_datapath #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  fsc_pkg::fsc_cmd_t   cmd,
  output fsc_pkg::fsc_status_t status,
  input  logic                matrix_select,
  input  logic [3:0]          element_index,
  input  logic signed [31:0]  element_value,
  input  logic signed [31:0]  center_x,
  input  logic signed [31:0]  center_y,
  input  logic signed [31:0]  center_z,
  input  logic [30:0]         sphere_radius,
  output logic                visible
);
  import fsc_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int DW = W + F;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [63:0] WMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN64 = -WMAX64 - 64'sd1;
  localparam logic [PW-1:0] LIMP = PW'($unsigned(WMAX));
  localparam logic signed [W-1:0] ONE = (F >= W - 1) ? WMAX : W'(64'sd1 <<< F);

  function automatic logic signed [W-1:0] clamp64(input logic signed [63:0] v);
    if (v > WMAX64) clamp64 = WMAX;
    else if (v < WMIN64) clamp64 = WMIN;
    else clamp64 = v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_sum(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b,
                                                  input logic sub);
    logic signed [W:0] s;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (s[W] != s[W-1]) sat_sum = s[W] ? WMIN : WMAX;
    else sat_sum = s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_mag(input logic [PW-1:0] m,
                                                  input logic neg);
    logic [PW-1:0] t;
    t = -m;
    if (neg) sat_mag = (m > LIMP + PW'(1)) ? WMIN : t[W-1:0];
    else sat_mag = (m > LIMP) ? WMAX : m[W-1:0];
  endfunction

  function automatic logic [W-1:0] absw(input logic signed [W-1:0] a);
    logic [W-1:0] t;
    t = -a;
    absw = a[W-1] ? t : a;
  endfunction

  logic signed [W-1:0] proj  [16];
  logic signed [W-1:0] mv    [16];
  logic signed [W-1:0] clip  [16];
  logic signed [W-1:0] plane [24];

  logic signed [W-1:0] cx, cy, cz, nrad, wreg, acc;
  logic                vis;
  logic [PW-1:0]       prod_mag, sumsq, rad;
  logic                prod_neg;
  logic [W+1:0]        srem;
  logic [W-1:0]        root;
  logic [DW-1:0]       dvd, quo;
  logic [W-1:0]        drem;
  logic                dneg;

  logic [4:0]          pl_addr;
  logic [3:0]          cl_addr;
  logic signed [W-1:0] pl_rd, cl_rd, center, mul_a, mul_b, prod_q, acc_base;
  logic [PW-1:0]       prod_full;
  logic [W+1:0]        rem_sh, trial;
  logic                sq_ge, dv_ge;
  logic [W:0]          drem_sh, drem_sub;
  logic signed [63:0]  rneg;

  always_comb begin
    unique case (cmd.op)
      OP_ACC_D:    pl_addr = {cmd.p, 2'd3};
      OP_DIV_INIT: pl_addr = {cmd.p, cmd.j};
      default:     pl_addr = {cmd.p, cmd.k};
    endcase
    pl_rd   = plane[pl_addr];
    cl_addr = (cmd.op == OP_RD_W) ? {cmd.j, 2'd3} : {cmd.j, cmd.p[2:1]};
    cl_rd   = clip[cl_addr];
    unique case (cmd.k)
      2'd0:    center = cx;
      2'd1:    center = cy;
      default: center = cz;
    endcase
    unique case (cmd.op)
      OP_MUL_CLIP: begin
        mul_a = mv[{cmd.idx[3:2], cmd.k}];
        mul_b = proj[{cmd.k, cmd.idx[1:0]}];
      end
      OP_MUL_TEST: begin
        mul_a = pl_rd;
        mul_b = center;
      end
      default: begin
        mul_a = pl_rd;
        mul_b = pl_rd;
      end
    endcase
  end

  assign prod_full = PW'(absw(mul_a)) * PW'(absw(mul_b));
  assign prod_q    = sat_mag(prod_mag >> F, prod_neg);
  assign acc_base  = (cmd.k == 2'd0) ? '0 : acc;

  // restoring square root, one result bit per step
  assign rem_sh = {srem[W-1:0], rad[PW-1:PW-2]};
  assign trial  = {root, 2'b01};
  assign sq_ge  = (rem_sh >= trial);

  // restoring divide by the normal length
  assign drem_sh  = {drem, dvd[DW-1]};
  assign drem_sub = drem_sh - {1'b0, root};
  assign dv_ge    = (drem_sh >= {1'b0, root});

  assign rneg = 64'sd0 - $signed(64'(sphere_radius));

  assign status.len_zero = (root == '0);
  assign visible = vis;

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        proj[i] <= '0;
        mv[i]   <= '0;
      end
      for (int i = 0; i < 24; i++) begin
        plane[i] <= (i == 3) ? ONE : '0;
      end
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          if (matrix_select) mv[element_index] <= clamp64(64'(element_value));
          else proj[element_index] <= clamp64(64'(element_value));
        end
        OP_PLANE_WR: plane[{cmd.p, cmd.j}] <= sat_sum(wreg, cl_rd, !PLANE_ADD[cmd.p]);
        OP_DIV_WR:   plane[{cmd.p, cmd.j}] <= sat_mag(PW'(quo), dneg);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        cx   <= clamp64(64'(center_x));
        cy   <= clamp64(64'(center_y));
        cz   <= clamp64(64'(center_z));
        nrad <= clamp64(rneg);
        vis  <= 1'b1;
      end
      OP_MUL_CLIP, OP_MUL_TEST, OP_MUL_SQ: begin
        prod_mag <= prod_full;
        prod_neg <= mul_a[W-1] ^ mul_b[W-1];
      end
      OP_ACC:     acc <= sat_sum(acc_base, prod_q, 1'b0);
      OP_ACC_D:   acc <= sat_sum(acc, pl_rd, 1'b0);
      OP_CMP:     if (acc < nrad) vis <= 1'b0;
      OP_CLIP_WR: clip[cmd.idx] <= acc;
      OP_RD_W:    wreg <= cl_rd;
      OP_SQ_ADD:  sumsq <= ((cmd.k == 2'd0) ? '0 : sumsq) + prod_mag;
      OP_SQRT_INIT: begin
        rad  <= sumsq;
        srem <= '0;
        root <= '0;
      end
      OP_SQRT_STEP: begin
        rad  <= rad << 2;
        srem <= sq_ge ? (rem_sh - trial) : rem_sh;
        root <= {root[W-2:0], sq_ge};
      end
      OP_DIV_INIT: begin
        dvd  <= DW'(absw(pl_rd)) << F;
        drem <= '0;
        quo  <= '0;
        dneg <= pl_rd[W-1];
      end
      OP_DIV_STEP: begin
        dvd  <= dvd << 1;
        drem <= dv_ge ? drem_sub[W-1:0] : drem_sh[W-1:0];
        quo  <= {quo[DW-2:0], dv_ge};
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/fsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fsc_ctrl
// sequencer for loads, plane extraction and sphere tests
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frustum_sphere_cull_top_macros.svh"
module fsc_ctrl #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           action,
  input  fsc_pkg::fsc_status_t status,
  output fsc_pkg::fsc_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import fsc_pkg::*;

  localparam int DW = WORD_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(DW);

  fsc_state_t state, state_next;
  logic [3:0]    idx;
  logic [1:0]    k, j;
  logic [2:0]    p;
  logic [CW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      k     <= '0;
      j     <= '0;
      p     <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          k   <= '0;
          j   <= '0;
          p   <= '0;
          cnt <= '0;
        end
        S_T_ADD:  k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        S_T_CMP:  p <= p + 3'd1;
        S_C_ADD:  k <= k + 2'd1;
        S_C_WR:   idx <= idx + 4'd1;
        S_P_WR:   j <= j + 2'd1;
        S_N_ADD:  k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        S_N_SQI:  cnt <= '0;
        S_N_SQS:  cnt <= cnt + CW'(1);
        S_N_CHK:  if (status.len_zero) p <= p + 3'd1;
        S_N_DVI:  cnt <= '0;
        S_N_DVS:  cnt <= cnt + CW'(1);
        S_N_DVW: begin
          j <= j + 2'd1;
          if (j == 2'd3) p <= p + 3'd1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && action == ACT_EXTRACT) state_next = S_C_MUL;
        else if (start && action == ACT_TEST) state_next = S_T_MUL;
      end
      S_T_MUL:  state_next = S_T_ADD;
      S_T_ADD:  state_next = (k == 2'd2) ? S_T_ADDD : S_T_MUL;
      S_T_ADDD: state_next = S_T_CMP;
      S_T_CMP:  state_next = (p == 3'd5) ? S_T_OUT : S_T_MUL;
      S_T_OUT:  state_next = S_IDLE;
      S_C_MUL:  state_next = S_C_ADD;
      S_C_ADD:  state_next = (k == 2'd3) ? S_C_WR : S_C_MUL;
      S_C_WR:   state_next = (idx == 4'd15) ? S_P_RDW : S_C_MUL;
      S_P_RDW:  state_next = S_P_WR;
      S_P_WR:   state_next = (j == 2'd3) ? S_N_MUL : S_P_RDW;
      S_N_MUL:  state_next = S_N_ADD;
      S_N_ADD:  state_next = (k == 2'd2) ? S_N_SQI : S_N_MUL;
      S_N_SQI:  state_next = S_N_SQS;
      S_N_SQS:  state_next = (cnt == CW'(WORD_WIDTH - 1)) ? S_N_CHK : S_N_SQS;
      S_N_CHK: begin
        if (!status.len_zero) state_next = S_N_DVI;
        else state_next = (p == 3'd5) ? S_IDLE : S_P_RDW;
      end
      S_N_DVI:  state_next = S_N_DVS;
      S_N_DVS:  state_next = (cnt == CW'(DW - 1)) ? S_N_DVW : S_N_DVS;
      S_N_DVW: begin
        if (j != 2'd3) state_next = S_N_DVI;
        else state_next = (p == 3'd5) ? S_IDLE : S_P_RDW;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.idx = idx;
    cmd.k   = k;
    cmd.j   = j;
    cmd.p   = p;
    busy    = (state != S_IDLE);
    done    = (state == S_T_OUT);
    unique case (state)
      S_IDLE: begin
        if (start && action == ACT_LOAD) cmd.op = OP_LOAD;
        else if (start && action == ACT_TEST) cmd.op = OP_CAPTURE;
        else cmd.op = OP_NONE;
      end
      S_T_MUL:  cmd.op = OP_MUL_TEST;
      S_T_ADD:  cmd.op = OP_ACC;
      S_T_ADDD: cmd.op = OP_ACC_D;
      S_T_CMP:  cmd.op = OP_CMP;
      S_C_MUL:  cmd.op = OP_MUL_CLIP;
      S_C_ADD:  cmd.op = OP_ACC;
      S_C_WR:   cmd.op = OP_CLIP_WR;
      S_P_RDW:  cmd.op = OP_RD_W;
      S_P_WR:   cmd.op = OP_PLANE_WR;
      S_N_MUL:  cmd.op = OP_MUL_SQ;
      S_N_ADD:  cmd.op = OP_SQ_ADD;
      S_N_SQI:  cmd.op = OP_SQRT_INIT;
      S_N_SQS:  cmd.op = OP_SQRT_STEP;
      S_N_DVI:  cmd.op = OP_DIV_INIT;
      S_N_DVS:  cmd.op = OP_DIV_STEP;
      S_N_DVW:  cmd.op = OP_DIV_WR;
      default:  cmd.op = OP_NONE;
    endcase
  end

  `FSC_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `FSC_ASSERT_NEXT(a_test_goes_busy, clk, rst, start && !busy && action == ACT_TEST, busy)
  `FSC_ASSERT_IMPL(a_done_last_plane, clk, rst, done, $past(busy) && p == 3'd6)

endmodule

@@ rtl/frustum_sphere_cull_top.sv @@
// sphere test: busy from the accepting edge, visible strobed by done in the last
//   busy cycle (6 planes through the one shared multiplier)
// load: busy never rises; extract: dominated by the bit-serial square root
//   and divider
// one item at a time; done cannot be held off by the receiver
// synchronous reset: matrices zero, planes zero except first plane offset 1.0
// ----------------------------------------------------------------------------
// frustum_sphere_cull_top
// fixed-point frustum plane extraction and sphere culling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module frustum_sphere_cull_top #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic               matrix_select,
  input  logic [3:0]         element_index,
  input  logic signed [31:0] element_value,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        sphere_radius,
  output logic               done,
  output logic               visible
);
  import fsc_pkg::*;

  // command from the sequencer, status back from the datapath
  fsc_cmd_t    cmd;
  fsc_status_t status;

  // sequencer: walks the clip products, plane sums, sqrt and divide steps
  // and the six per-plane distance checks of a sphere test
  fsc_ctrl #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .action(action),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath: matrix and plane registers, one multiplier, saturating
  // accumulator, restoring sqrt and restoring divider
  fsc_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .matrix_select(matrix_select),
    .element_index(element_index),
    .element_value(element_value),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_z     (center_z),
    .sphere_radius(sphere_radius),
    .visible      (visible)
  );

endmodule

@@ tb/tb_frustum_sphere_cull_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frustum_sphere_cull_top
// self-checking bench for the fixed-point frustum culler: matrix loads, plane
// extraction and sphere tests are checked against a bit-exact predictor
// ----------------------------------------------------------------------------
module tb_frustum_sphere_cull_top;
  import fsc_pkg::*;

  // action code the block must ignore
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  // worst-case extraction length, rounded up, used before the final check
  localparam int EXTRACT_CYCLES = 2000;

  typedef struct {
    logic [1:0]         act;
    logic               sel;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        rad;
  } cull_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         action = ACT_LOAD;
  logic               matrix_select = 1'b0;
  logic [3:0]         element_index = '0;
  logic signed [31:0] element_value = '0;
  logic signed [31:0] center_x = '0;
  logic signed [31:0] center_y = '0;
  logic signed [31:0] center_z = '0;
  logic [30:0]        sphere_radius = '0;
  logic               done;
  logic               visible;

  frustum_sphere_cull_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .matrix_select(matrix_select),
    .element_index(element_index), .element_value(element_value),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .sphere_radius(sphere_radius), .done(done), .visible(visible)
  );

  always #2 clk = ~clk;

  // predictor state: both matrices and six planes of a, b, c, d
  longint proj_mat[16];
  longint view_mat[16];
  longint plane_coef[24];
  logic   visible_expected[$];
  int     err_count = 0;
  bit     idle_on = 1'b1;

  // ---------------------------------------------------------------- arithmetic
  function automatic longint sat_word(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint signed_from_mag(bit neg, longint unsigned m);
    if (neg) begin
      if (m > 64'd2147483648) return WMIN;
      return -longint'(m);
    end
    if (m > 64'd2147483647) return WMAX;
    return longint'(m);
  endfunction

  // product truncated toward zero by the fraction bits, then saturated
  function automatic longint qmul(longint a, longint b);
    longint unsigned m;
    m = (mag(a) * mag(b)) >> 16;
    return signed_from_mag((a < 0) != (b < 0), m);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    logic [127:0] r, c;
    r = '0;
    for (int i = 48; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= {64'd0, n}) r = c;
    end
    return r[63:0];
  endfunction

  // restoring division of num << 16 by len, quotient capped at 2^31
  function automatic longint qdiv(longint num, longint unsigned len);
    longint unsigned u, rem, q, b;
    u = mag(num);
    rem = 0;
    q = 0;
    for (int i = 47; i >= 0; i--) begin
      b = (i >= 16) ? ((u >> (i - 16)) & 1) : 0;
      rem = (rem << 1) | b;
      q = q << 1;
      if (rem >= len) begin
        rem -= len;
        q |= 1;
      end
      if (q > 64'd2147483648) q = 64'd2147483648;
    end
    return signed_from_mag(num < 0, q);
  endfunction

  // clip = projection * modelview, then six planes from row sums/differences
  task automatic extract_planes();
    longint clip[16];
    longint acc;
    longint unsigned sq, len;
    int sel[6] = '{0, 0, 1, 1, 2, 2};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 0;
        for (int k = 0; k < 4; k++)
          acc = sat_word(acc + qmul(view_mat[c*4+k], proj_mat[k*4+r]));
        clip[c*4+r] = acc;
      end
    for (int p = 0; p < 6; p++) begin
      for (int j = 0; j < 4; j++)
        plane_coef[p*4+j] = PLANE_ADD[p] ? sat_word(clip[j*4+3] + clip[j*4+sel[p]])
                                         : sat_word(clip[j*4+3] - clip[j*4+sel[p]]);
      sq = 0;
      for (int k = 0; k < 3; k++) sq += mag(plane_coef[p*4+k]) * mag(plane_coef[p*4+k]);
      len = isqrt(sq);
      // zero-length normal: plane kept as it is
      if (len != 0)
        for (int j = 0; j < 4; j++) plane_coef[p*4+j] = qdiv(plane_coef[p*4+j], len);
    end
  endtask

  function automatic logic sphere_visible(cull_item_t it);
    longint d, nr;
    nr = -longint'(it.rad);
    for (int p = 0; p < 6; p++) begin
      d = qmul(plane_coef[p*4], it.cx);
      d = sat_word(d + qmul(plane_coef[p*4+1], it.cy));
      d = sat_word(d + qmul(plane_coef[p*4+2], it.cz));
      d = sat_word(d + plane_coef[p*4+3]);
      if (d < nr) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic cull_predict(cull_item_t it);
    case (it.act)
      ACT_LOAD: begin
        if (it.sel) view_mat[it.idx] = it.val;
        else proj_mat[it.idx] = it.val;
      end
      ACT_EXTRACT: extract_planes();
      ACT_TEST: visible_expected.push_back(sphere_visible(it));
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------------ driving
  // one item: present it, wait for the accepting edge, then maybe idle
  task automatic send_item(cull_item_t it);
    int gap;
    action <= it.act;
    matrix_select <= it.sel;
    element_index <= it.idx;
    element_value <= it.val;
    center_x <= it.cx;
    center_y <= it.cy;
    center_z <= it.cz;
    sphere_radius <= it.rad;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    cull_predict(it);
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic cull_item_t mk_load(logic sel, logic [3:0] idx, logic signed [31:0] v);
    cull_item_t it;
    it = '{act: ACT_LOAD, sel: sel, idx: idx, val: v, cx: $urandom, cy: $urandom,
           cz: $urandom, rad: 31'($urandom)};
    return it;
  endfunction

  function automatic cull_item_t mk_op(logic [1:0] act);
    cull_item_t it;
    it = '{act: act, sel: 1'($urandom), idx: 4'($urandom), val: $urandom, cx: $urandom,
           cy: $urandom, cz: $urandom, rad: 31'($urandom)};
    return it;
  endfunction

  function automatic cull_item_t mk_sphere(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z, logic [30:0] r);
    cull_item_t it;
    it = mk_op(ACT_TEST);
    it.cx = x;
    it.cy = y;
    it.cz = z;
    it.rad = r;
    return it;
  endfunction

  // signed value spread over +-2^bits
  function automatic logic signed [31:0] rnd_q(int bits);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> (31 - bits);
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (visible_expected.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    if (!rst && done) begin
      if (visible_expected.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result: visible=%0b", visible);
      end else begin
        logic exp_vis;
        exp_vis = visible_expected.pop_front();
        if (visible !== exp_vis) begin
          err_count++;
          if (err_count <= 10)
            $display("visible mismatch: expected %0b actual %0b", exp_vis, visible);
        end
      end
    end
  end

  // ------------------------------------------------------------------- tests
  // reset planes: only the first plane's offset is set, all spheres visible
  task automatic test_reset_state();
    send_item(mk_sphere(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, '0));
    send_item(mk_sphere(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff));
    send_item(mk_op(ACT_NONE));
  endtask

  // zero matrices give zero-length normals, left unnormalized
  task automatic test_zero_planes();
    send_item(mk_op(ACT_EXTRACT));
    send_item(mk_sphere(32'sh00010000, 0, 0, 0));
    send_item(mk_sphere(32'sh80000000, 32'sh80000000, 32'sh80000000, 0));
  endtask

  // extreme element values saturate through the clip product
  task automatic test_load_extremes();
    send_item(mk_load(1'b0, 4'd0, 32'sh7fffffff));
    send_item(mk_load(1'b0, 4'd15, 32'sh80000000));
    send_item(mk_load(1'b1, 4'd0, 32'sh80000000));
    send_item(mk_load(1'b1, 4'd15, 32'sh7fffffff));
    send_item(mk_op(ACT_NONE));
    send_item(mk_op(ACT_EXTRACT));
    send_item(mk_sphere(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff));
    send_item(mk_sphere(32'sh80000000, 0, 32'sh80000000, 0));
  endtask

  // identity matrices: unit cube frustum, spheres inside and outside
  task automatic test_identity_frustum();
    for (int i = 0; i < 16; i++) begin
      proj_mat[i] = proj_mat[i];
      send_item(mk_load(1'b0, i[3:0], (i % 5 == 0) ? 32'sh00010000 : 32'sh0));
      send_item(mk_load(1'b1, i[3:0], (i % 5 == 0) ? 32'sh00010000 : 32'sh0));
    end
    send_item(mk_op(ACT_EXTRACT));
    send_item(mk_sphere(0, 0, 0, 0));
    send_item(mk_sphere(32'sh00020000, 0, 0, 31'h00008000));
    send_item(mk_sphere(32'sh00020000, 0, 0, 31'h00018000));
    send_item(mk_sphere(0, 32'shfffe0000, 0, 31'h00008000));
    send_item(mk_sphere(0, 0, 32'sh00020000, 31'h00010000));
  endtask

  // random matrices, mostly frustum-like, then mixed bursts of sphere tests
  task automatic test_random(int n_items);
    int sent, k;
    bit full;
    sent = 0;
    k = 0;
    while (sent < n_items) begin
      idle_on = ($urandom_range(0, 3) != 0);
      full = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < 32; i++) begin
        send_item(mk_load(i[4], i[3:0], full ? rnd_q(31) : rnd_q(18)));
        sent++;
      end
      send_item(mk_op(ACT_EXTRACT));
      for (int i = $urandom_range(40, 80); i > 0; i--) begin
        case ($urandom_range(0, 19))
          0: send_item(mk_op(ACT_NONE));
          1: send_item(mk_load(1'($urandom), 4'($urandom), rnd_q(31)));
          2: send_item(mk_op(ACT_TEST));
          default: send_item(mk_sphere(rnd_q(19), rnd_q(19), rnd_q(19),
                                       31'($urandom_range(0, 1 << 18))));
        endcase
        sent++;
      end
      // one hold-off until the block has answered everything
      if (k++ == 2) wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      proj_mat[i] = 0;
      view_mat[i] = 0;
    end
    for (int i = 0; i < 24; i++) plane_coef[i] = 0;
    plane_coef[3] = 64'sd65536;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_zero_planes();
    test_load_extremes();
    test_identity_frustum();
    test_random(1100);
    start <= 1'b0;
    while (visible_expected.size() != 0) @(posedge clk);
    // an extraction may still be running with nothing expected
    repeat (EXTRACT_CYCLES) @(posedge clk);
    if (err_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
